FILE: design/wsd_pkg.sv
// ============================================================================
// WebSocket deframer package
// Shared types, codes and helper functions for the WebSocket frame deframer.
// ============================================================================
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_PAY  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        KIND_MSG          = 3'd0,
        KIND_PING         = 3'd1,
        KIND_EMPTY_MSG    = 3'd2,
        KIND_EMPTY_PING   = 3'd3,
        KIND_CLOSE        = 3'd4,
        KIND_BAD_OPCODE   = 3'd5,
        KIND_PING_TOO_BIG = 3'd6,
        KIND_PING_NOT_FIN = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       is_binary;
        logic       last;
    } result_t;

    localparam logic [6:0] OP_CONT  = 7'd0;
    localparam logic [6:0] OP_TEXT  = 7'd1;
    localparam logic [6:0] OP_BIN   = 7'd2;
    localparam logic [6:0] OP_CLOSE = 7'd8;
    localparam logic [6:0] OP_PING  = 7'd9;
    localparam logic [6:0] OP_PONG  = 7'd10;

    localparam logic [6:0]  LEN_EXT16      = 7'd126;
    localparam logic [6:0]  LEN_EXT64      = 7'd127;
    localparam logic [31:0] PING_MAX_LEN   = 32'd125;
    localparam logic [3:0]  EXT16_BYTES    = 4'd2;
    localparam logic [3:0]  EXT64_BYTES    = 4'd8;
    localparam logic [3:0]  KEY_BYTES      = 4'd4;

    function automatic logic is_data_op(input logic [6:0] op);
        return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN);
    endfunction

    function automatic logic op_known(input logic [6:0] op);
        return is_data_op(op) || (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

FILE: design/wsd_in_reg.sv
// ============================================================================
// Input register
// Holds one received byte until the parser takes it.
// ============================================================================
module wsd_in_reg
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_value
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_value = byte_reg;

endmodule

FILE: design/wsd_parser.sv
// ============================================================================
// Frame parser
// Walks the header fields, unmasks payload bytes and forms at most one result per byte.
// ============================================================================
module wsd_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       byte_value,
    output logic             res_valid,
    output wsd_pkg::result_t res
);
    import wsd_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic        fin_reg,      fin_next;
    logic [6:0]  op_reg,       op_next;
    logic        mask_reg,     mask_next;
    logic [3:0]  ext_reg,      ext_next;
    logic [31:0] len_reg,      len_next;
    logic [1:0]  idx_reg,      idx_next;
    logic        small_reg,    small_next;
    logic [31:0] key_reg,      key_next;
    logic        msg_bin_reg,  msg_bin_next;
    logic        halted_reg,   halted_next;

    logic        hdr_done;
    logic        start_pay;
    logic [31:0] start_len;
    logic [31:0] len_shift;
    logic        end_fr;
    logic        end_have;
    logic        end_small;
    logic [7:0]  key_byte;
    logic [7:0]  pay_byte;
    logic        frame_bin;

    assign len_shift = {len_reg[23:0], byte_value};
    assign frame_bin = (op_reg == OP_CONT) ? msg_bin_reg : (op_reg == OP_BIN);

    always_comb
    begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign pay_byte = byte_value ^ key_byte;

    always_comb
    begin
        phase_next   = phase_reg;
        fin_next     = fin_reg;
        op_next      = op_reg;
        mask_next    = mask_reg;
        ext_next     = ext_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        small_next   = small_reg;
        key_next     = key_reg;
        msg_bin_next = msg_bin_reg;
        halted_next  = halted_reg;
        hdr_done     = 1'b0;
        start_pay    = 1'b0;
        start_len    = len_reg;
        end_fr       = 1'b0;
        end_have     = 1'b0;
        end_small    = small_reg;
        res_valid    = 1'b0;
        res          = '{kind: KIND_MSG, data: 8'd0, is_binary: 1'b0, last: 1'b0};

        if (fire && !halted_reg)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    fin_next = byte_value[7];
                    op_next  = byte_value[6:0];
                    if (!op_known(byte_value[6:0]))
                    begin
                        halted_next = 1'b1;
                        res_valid   = 1'b1;
                        res.kind    = KIND_BAD_OPCODE;
                    end
                    else
                    begin
                        if (!byte_value[7] &&
                            (byte_value[6:0] == OP_TEXT || byte_value[6:0] == OP_BIN))
                        begin
                            msg_bin_next = (byte_value[6:0] == OP_BIN);
                        end
                        phase_next = PH_HDR1;
                    end
                end
                PH_HDR1:
                begin
                    mask_next = byte_value[7];
                    len_next  = 32'd0;
                    if (byte_value[6:0] == LEN_EXT16)
                    begin
                        ext_next   = EXT16_BYTES;
                        phase_next = PH_EXT;
                    end
                    else if (byte_value[6:0] == LEN_EXT64)
                    begin
                        ext_next   = EXT64_BYTES;
                        phase_next = PH_EXT;
                    end
                    else
                    begin
                        start_len = {25'd0, byte_value[6:0]};
                        len_next  = start_len;
                        hdr_done  = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    len_next = len_shift;
                    if (ext_reg != 4'd0)
                    begin
                        ext_next = ext_reg - 4'd1;
                    end
                    if (ext_reg <= 4'd1)
                    begin
                        start_len = len_shift;
                        hdr_done  = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], byte_value};
                    if (ext_reg != 4'd0)
                    begin
                        ext_next = ext_reg - 4'd1;
                    end
                    if (ext_reg <= 4'd1)
                    begin
                        start_len = len_reg;
                        start_pay = 1'b1;
                    end
                end
                PH_PAY:
                begin
                    len_next = len_reg - 32'd1;
                    idx_next = idx_reg + 2'd1;
                    if (len_reg <= 32'd1)
                    begin
                        end_fr   = 1'b1;
                        end_have = 1'b1;
                    end
                    else if (is_data_op(op_reg))
                    begin
                        res_valid     = 1'b1;
                        res.kind      = KIND_MSG;
                        res.data      = pay_byte;
                        res.is_binary = frame_bin;
                    end
                    else if (op_reg == OP_PING && fin_reg && small_reg)
                    begin
                        res_valid = 1'b1;
                        res.kind  = KIND_PING;
                        res.data  = pay_byte;
                    end
                end
                default:
                begin
                    end_fr = 1'b0;
                end
            endcase

            if (hdr_done)
            begin
                key_next = 32'd0;
                if (mask_next)
                begin
                    phase_next = PH_KEY;
                    ext_next   = KEY_BYTES;
                end
                else
                begin
                    start_pay = 1'b1;
                end
            end

            if (start_pay)
            begin
                if (start_len == 32'd0)
                begin
                    end_fr    = 1'b1;
                    end_small = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAY;
                    len_next   = start_len;
                    idx_next   = 2'd0;
                    small_next = (start_len <= PING_MAX_LEN);
                end
            end

            if (end_fr)
            begin
                if (is_data_op(op_reg))
                begin
                    if (end_have)
                    begin
                        res_valid     = 1'b1;
                        res.kind      = KIND_MSG;
                        res.data      = pay_byte;
                        res.is_binary = frame_bin;
                        res.last      = fin_reg;
                    end
                    else if (fin_reg)
                    begin
                        res_valid     = 1'b1;
                        res.kind      = KIND_EMPTY_MSG;
                        res.is_binary = frame_bin;
                        res.last      = 1'b1;
                    end
                    if (op_reg == OP_CONT && fin_reg)
                    begin
                        msg_bin_next = 1'b0;
                    end
                end
                else if (op_reg == OP_PING)
                begin
                    res_valid = 1'b1;
                    if (!fin_reg)
                    begin
                        halted_next = 1'b1;
                        res.kind    = KIND_PING_NOT_FIN;
                    end
                    else if (!end_small)
                    begin
                        halted_next = 1'b1;
                        res.kind    = KIND_PING_TOO_BIG;
                    end
                    else if (end_have)
                    begin
                        res.kind = KIND_PING;
                        res.data = pay_byte;
                        res.last = 1'b1;
                    end
                    else
                    begin
                        res.kind = KIND_EMPTY_PING;
                        res.last = 1'b1;
                    end
                end
                else if (op_reg == OP_CLOSE)
                begin
                    halted_next = 1'b1;
                    res_valid   = 1'b1;
                    res.kind    = KIND_CLOSE;
                end
                phase_next = PH_HDR0;
                fin_next   = 1'b0;
                op_next    = OP_CONT;
                mask_next  = 1'b0;
                ext_next   = 4'd0;
                len_next   = 32'd0;
                idx_next   = 2'd0;
                key_next   = 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            fin_reg     <= 1'b0;
            op_reg      <= OP_CONT;
            mask_reg    <= 1'b0;
            ext_reg     <= 4'd0;
            len_reg     <= 32'd0;
            idx_reg     <= 2'd0;
            small_reg   <= 1'b0;
            key_reg     <= 32'd0;
            msg_bin_reg <= 1'b0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            fin_reg     <= fin_next;
            op_reg      <= op_next;
            mask_reg    <= mask_next;
            ext_reg     <= ext_next;
            len_reg     <= len_next;
            idx_reg     <= idx_next;
            small_reg   <= small_next;
            key_reg     <= key_next;
            msg_bin_reg <= msg_bin_next;
            halted_reg  <= halted_next;
        end
    end

endmodule

FILE: design/wsd_out_reg.sv
// ============================================================================
// Result register
// Holds one result until the downstream side takes it.
// ============================================================================
module wsd_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  wsd_pkg::result_t res,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic [3:0]       m_tuser,
    output logic             m_tlast
);
    import wsd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.data;
    assign m_tuser  = {res_reg.is_binary, res_reg.kind};
    assign m_tlast  = res_reg.last;

endmodule

FILE: design/websocket_frame_deframer.sv
// ============================================================================
// WebSocket frame deframer
// Parses received WebSocket frames byte by byte and streams unmasked payload.
// ============================================================================
// The block takes one received byte per cycle while the result register can
// accept a result, and gives at most one result per byte. Each byte passes
// through the input register, then through the header parser and unmasking
// XOR into the result register. Throughput is one byte per cycle, held back
// only by downstream backpressure on the result register. After a close
// frame, an unknown opcode or a bad ping frame is reported, all further
// bytes are taken and dropped until reset.
module websocket_frame_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data
    output logic [3:0] m_tuser,   // [2:0] kind, [3] is_binary
    output logic       m_tlast
);
    import wsd_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_value;
    logic       out_free;
    logic       fire;
    logic       res_valid;
    result_t    res;

    assign fire = byte_valid && out_free;

    wsd_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (fire),
        .byte_valid (byte_valid),
        .byte_value (byte_value)
    );

    wsd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .byte_value (byte_value),
        .res_valid  (res_valid),
        .res        (res)
    );

    wsd_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: design/wsd_checker.sv
// ============================================================================
// Deframer port checker
// Checks result stream properties seen at the deframer ports.
// ============================================================================
module wsd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [3:0] m_tuser,
    input logic       m_tlast
);
    import wsd_pkg::*;

    logic [2:0] kind;
    logic       fatal;

    assign kind      = m_tuser[2:0];
    assign fatal     = (kind == KIND_CLOSE) || (kind == KIND_BAD_OPCODE) ||
                       (kind == KIND_PING_TOO_BIG) || (kind == KIND_PING_NOT_FIN);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("Stalled result changed.");

    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && fatal |=> !m_tvalid)
        else $error("Result after a halting report.");

    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && kind != KIND_MSG && kind != KIND_PING |-> m_tdata == 8'd0)
        else $error("Nonzero data on a report.");

    a_binary: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && kind != KIND_MSG && kind != KIND_EMPTY_MSG |-> !m_tuser[3])
        else $error("Binary flag on a non-message result.");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!fatal || !m_tlast) &&
            ((kind != KIND_EMPTY_MSG && kind != KIND_EMPTY_PING) || m_tlast))
        else $error("Wrong last flag on a report.");

endmodule

bind websocket_frame_deframer wsd_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: test/tb_websocket_frame_deframer.sv
`timescale 1ns / 100ps
// ============================================================================
// WebSocket frame deframer testbench
// Streams WebSocket frames byte by byte into the deframer with random gaps
// and random backpressure, predicts every result from its own model of the
// frame parser, and checks each result transfer against the oldest
// prediction. Well-formed messages, fragments, pings and pongs fill most of
// the run, and a single frame that halts the block closes it.
// ============================================================================
module tb_websocket_frame_deframer;

    import wsd_pkg::*;

    typedef enum int {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } len_form_t;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_BYTES = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;

    logic       s_fire = 1'b0;
    logic [7:0] rx_bytes[$];
    result_t    expected_results[$];
    int         mismatches = 0;
    int         cycles = 0;
    int         send_gap = 0;
    int         send_calm = 0;
    int         recv_gap = 0;
    int         recv_calm = 0;

    phase_t      dp_phase = PH_HDR0;
    logic        dp_fin = 1'b0;
    logic [6:0]  dp_opcode = OP_CONT;
    logic        dp_masked = 1'b0;
    logic [3:0]  dp_left = 4'd0;
    logic [31:0] dp_length = 32'd0;
    logic [31:0] dp_count = 32'd0;
    logic [31:0] dp_key = 32'd0;
    logic        dp_msg_binary = 1'b0;
    logic        dp_halted = 1'b0;

    websocket_frame_deframer dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic carries_data(input logic [6:0] op);
        return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN);
    endfunction

    function automatic logic frame_is_binary();
        return (dp_opcode == OP_CONT) ? dp_msg_binary : (dp_opcode == OP_BIN);
    endfunction

    task automatic append_byte(input logic [7:0] b);
        rx_bytes.insert(rx_bytes.size(), b);
    endtask

    task automatic expect_result(input kind_t k, input logic [7:0] d, input logic bin,
                                 input logic tail);
        result_t r;
        r.kind      = k;
        r.data      = d;
        r.is_binary = bin;
        r.last      = tail;
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic reset_frame();
        dp_phase  = PH_HDR0;
        dp_fin    = 1'b0;
        dp_opcode = OP_CONT;
        dp_masked = 1'b0;
        dp_left   = 4'd0;
        dp_length = 32'd0;
        dp_count  = 32'd0;
        dp_key    = 32'd0;
    endtask

    task automatic finish_frame(input logic have_byte, input logic [7:0] d);
        if (carries_data(dp_opcode))
        begin
            if (have_byte)
                expect_result(KIND_MSG, d, frame_is_binary(), dp_fin);
            else if (dp_fin)
                expect_result(KIND_EMPTY_MSG, 8'h00, frame_is_binary(), 1'b1);
            if (dp_opcode == OP_CONT && dp_fin)
                dp_msg_binary = 1'b0;
        end
        else if (dp_opcode == OP_PING)
        begin
            if (!dp_fin)
            begin
                dp_halted = 1'b1;
                expect_result(KIND_PING_NOT_FIN, 8'h00, 1'b0, 1'b0);
            end
            else if (dp_length > PING_MAX_LEN)
            begin
                dp_halted = 1'b1;
                expect_result(KIND_PING_TOO_BIG, 8'h00, 1'b0, 1'b0);
            end
            else if (have_byte)
                expect_result(KIND_PING, d, 1'b0, 1'b1);
            else
                expect_result(KIND_EMPTY_PING, 8'h00, 1'b0, 1'b1);
        end
        else if (dp_opcode == OP_CLOSE)
        begin
            dp_halted = 1'b1;
            expect_result(KIND_CLOSE, 8'h00, 1'b0, 1'b0);
        end
        reset_frame();
    endtask

    task automatic start_payload();
        if (dp_length == 32'd0)
            finish_frame(1'b0, 8'h00);
        else
        begin
            dp_phase = PH_PAY;
            dp_count = 32'd0;
        end
    endtask

    task automatic header_done();
        dp_key = 32'd0;
        if (dp_masked)
        begin
            dp_phase = PH_KEY;
            dp_left  = KEY_BYTES;
        end
        else
            start_payload();
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [31:0] key_shifted;
        logic [7:0]  plain;
        key_shifted = dp_key >> (5'd24 - {dp_count[1:0], 3'b000});
        plain       = b ^ key_shifted[7:0];
        if (!dp_halted)
        begin
            case (dp_phase)
                PH_HDR0:
                begin
                    dp_fin    = b[7];
                    dp_opcode = b[6:0];
                    if (!(carries_data(dp_opcode) || dp_opcode == OP_CLOSE ||
                          dp_opcode == OP_PING || dp_opcode == OP_PONG))
                    begin
                        dp_halted = 1'b1;
                        expect_result(KIND_BAD_OPCODE, 8'h00, 1'b0, 1'b0);
                    end
                    else
                    begin
                        if (!dp_fin && (dp_opcode == OP_TEXT || dp_opcode == OP_BIN))
                            dp_msg_binary = (dp_opcode == OP_BIN);
                        dp_phase = PH_HDR1;
                    end
                end
                PH_HDR1:
                begin
                    dp_masked = b[7];
                    dp_length = 32'd0;
                    if (b[6:0] == LEN_EXT16)
                    begin
                        dp_left  = EXT16_BYTES;
                        dp_phase = PH_EXT;
                    end
                    else if (b[6:0] == LEN_EXT64)
                    begin
                        dp_left  = EXT64_BYTES;
                        dp_phase = PH_EXT;
                    end
                    else
                    begin
                        dp_length = {25'd0, b[6:0]};
                        header_done();
                    end
                end
                PH_EXT:
                begin
                    dp_length = {dp_length[23:0], b};
                    if (dp_left > 4'd0)
                        dp_left = dp_left - 4'd1;
                    if (dp_left == 4'd0)
                        header_done();
                end
                PH_KEY:
                begin
                    dp_key = {dp_key[23:0], b};
                    if (dp_left > 4'd0)
                        dp_left = dp_left - 4'd1;
                    if (dp_left == 4'd0)
                        start_payload();
                end
                PH_PAY:
                begin
                    dp_count = dp_count + 32'd1;
                    if (dp_count >= dp_length)
                        finish_frame(1'b1, plain);
                    else if (carries_data(dp_opcode))
                        expect_result(KIND_MSG, plain, frame_is_binary(), 1'b0);
                    else if (dp_opcode == OP_PING && dp_fin && dp_length <= PING_MAX_LEN)
                        expect_result(KIND_PING, plain, 1'b0, 1'b0);
                end
                default:
                    reset_frame();
            endcase
        end
    endtask

    task automatic push_frame(input logic fin, input logic [6:0] op, input logic masked,
                              input len_form_t form, input int unsigned len,
                              input logic [31:0] ext_hi);
        int i;
        append_byte({fin, op});
        case (form)
            FORM_SHORT:
                append_byte({masked, len[6:0]});
            FORM_EXT16:
            begin
                append_byte({masked, LEN_EXT16});
                append_byte(len[15:8]);
                append_byte(len[7:0]);
            end
            default:
            begin
                append_byte({masked, LEN_EXT64});
                for (i = 3; i >= 0; i--)
                    append_byte(ext_hi[8 * i +: 8]);
                for (i = 3; i >= 0; i--)
                    append_byte(len[8 * i +: 8]);
            end
        endcase
        if (masked)
            repeat (4) append_byte(8'($urandom_range(0, 255)));
        repeat (len) append_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic push_random_frame(input logic fin, input logic [6:0] op,
                                     input int unsigned max_len);
        int unsigned len;
        int          r;
        len_form_t   form;
        r = $urandom_range(0, 99);
        if (r < 65)
            len = $urandom_range(0, 8);
        else if (r < 95)
            len = $urandom_range(9, 60);
        else
            len = $urandom_range(126, 300);
        if (len > max_len)
            len = max_len;
        r = $urandom_range(0, 99);
        if (len > 125)
            form = (r < 70) ? FORM_EXT16 : FORM_EXT64;
        else if (r < 80)
            form = FORM_SHORT;
        else if (r < 92)
            form = FORM_EXT16;
        else
            form = FORM_EXT64;
        push_frame(fin, op, $urandom_range(0, 99) < 85, form, len, $urandom());
    endtask

    function automatic int idle_length(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_field(input string field, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, exp_v, act_v);
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_fire)
            begin
                if (send_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap--;
                end
                else if (rx_bytes.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_bytes.pop_front();
                    send_gap = idle_length(send_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
            if (recv_gap > 0)
            begin
                m_tready <= 1'b0;
                recv_gap--;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_gap = idle_length(recv_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected transfer, expected none, actual %0h %0h %0h %0h",
                             $time, m_tuser[2:0], m_tdata, m_tuser[3], m_tlast);
                end
                else
                begin
                    want = expected_results.pop_front();
                    report_field("kind", {5'd0, want.kind}, {5'd0, m_tuser[2:0]});
                    report_field("data", want.data, m_tdata);
                    report_field("is_binary", {7'd0, want.is_binary}, {7'd0, m_tuser[3]});
                    report_field("last", {7'd0, want.last}, {7'd0, m_tlast});
                end
            end
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
        end
        s_fire <= rst_n && s_tvalid && s_tready;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int         target;
        int         r;
        logic [6:0] op;

        push_frame(1'b1, OP_TEXT, 1'b0, FORM_SHORT, 3, 32'd0);
        push_frame(1'b1, OP_BIN, 1'b1, FORM_SHORT, 5, 32'd0);
        push_frame(1'b1, OP_TEXT, 1'b1, FORM_SHORT, 0, 32'd0);
        push_frame(1'b0, OP_BIN, 1'b1, FORM_SHORT, 0, 32'd0);
        push_frame(1'b0, OP_CONT, 1'b1, FORM_SHORT, 2, 32'd0);
        push_frame(1'b1, OP_PING, 1'b1, FORM_SHORT, 1, 32'd0);
        push_frame(1'b1, OP_CONT, 1'b0, FORM_SHORT, 0, 32'd0);
        push_frame(1'b0, OP_TEXT, 1'b1, FORM_EXT16, 2, 32'd0);
        push_frame(1'b1, OP_CONT, 1'b1, FORM_SHORT, 3, 32'd0);
        push_frame(1'b1, OP_PING, 1'b0, FORM_SHORT, 0, 32'd0);
        push_frame(1'b1, OP_PING, 1'b1, FORM_EXT16, 4, 32'd0);
        push_frame(1'b1, OP_PONG, 1'b1, FORM_SHORT, 3, 32'd0);
        push_frame(1'b1, OP_BIN, 1'b1, FORM_EXT64, 2, 32'hffff_ffff);
        push_frame(1'b1, OP_TEXT, 1'b1, FORM_EXT16, 0, 32'd0);
        push_frame(1'b1, OP_CONT, 1'b0, FORM_SHORT, 1, 32'd0);

        target = rx_bytes.size() + RANDOM_BYTES;
        while (rx_bytes.size() < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                push_random_frame(1'b1, $urandom_range(0, 1) ? OP_BIN : OP_TEXT, 300);
            else if (r < 65)
            begin
                push_random_frame(1'b0, $urandom_range(0, 1) ? OP_BIN : OP_TEXT, 300);
                repeat ($urandom_range(0, 3))
                begin
                    case ($urandom_range(0, 3))
                        0: push_random_frame(1'b1, OP_PING, 125);
                        1: push_random_frame(1'($urandom_range(0, 1)), OP_PONG, 300);
                        default: push_random_frame(1'b0, OP_CONT, 300);
                    endcase
                end
                push_random_frame(1'b1, OP_CONT, 300);
            end
            else if (r < 80)
            begin
                if ($urandom_range(0, 7) == 0)
                    push_frame(1'b1, OP_PING, 1'b1, FORM_SHORT, 125, 32'd0);
                else
                    push_random_frame(1'b1, OP_PING, 125);
            end
            else if (r < 88)
                push_random_frame(1'($urandom_range(0, 1)), OP_PONG, 300);
            else if ($urandom_range(0, 1) == 0)
                push_random_frame(1'($urandom_range(0, 1)), OP_CONT, 300);
            else
                push_random_frame(1'b0, $urandom_range(0, 1) ? OP_BIN : OP_TEXT, 300);
        end

        // Any of these halts the block for the rest of the run, so only one goes last.
        case ($urandom_range(0, 3))
            0: push_random_frame(1'($urandom_range(0, 1)), OP_CLOSE, 20);
            1:
            begin
                do
                    op = 7'($urandom_range(0, 127));
                while (carries_data(op) || op == OP_CLOSE || op == OP_PING || op == OP_PONG);
                append_byte({1'($urandom_range(0, 1)), op});
            end
            2: push_frame(1'b1, OP_PING, 1'($urandom_range(0, 1)), FORM_EXT16,
                          $urandom_range(126, 200), 32'd0);
            default: push_random_frame(1'b0, OP_PING, 125);
        endcase
        repeat (8) append_byte(8'($urandom_range(0, 255)));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (rx_bytes.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_results.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
